[rtl/rwsd_pkg.sv]
// shared types, constants and helper functions for the running window stddev weights core
package rwsd_pkg;

   // weighting mode codes
   localparam logic [2:0] MODE_EQUAL = 3'd0;
   localparam logic [2:0] MODE_ERROR = 3'd1;
   localparam logic [2:0] MODE_SD3   = 3'd2;
   localparam logic [2:0] MODE_SD5   = 3'd3;
   localparam logic [2:0] MODE_SD7   = 3'd4;
   localparam logic [2:0] MODE_SD11  = 3'd5;

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [31:0] SAT_W   = 32'h7FFF_FFFF;

   // pair sum width, divide step count (a multiply and a digit step per 16-bit digit) and square root step count
   localparam int ACC_W      = 80;
   localparam int DIV_STEPS  = 10;
   localparam int SQRT_STEPS = 31;

   // controller states, one-hot
   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_START = 14'b00000000000010,
      ST_WIN   = 14'b00000000000100,
      ST_PAIR  = 14'b00000000001000,
      ST_DRAIN = 14'b00000000010000,
      ST_DIV   = 14'b00000000100000,
      ST_SQI   = 14'b00000001000000,
      ST_SQRT  = 14'b00000010000000,
      ST_WRSD  = 14'b00000100000000,
      ST_CRD   = 14'b00001000000000,
      ST_CWR   = 14'b00010000000000,
      ST_ERD   = 14'b00100000000000,
      ST_ELD   = 14'b01000000000000,
      ST_EWAIT = 14'b10000000000000
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load_wr;
      logic       pair_issue;
      logic       acc_clear;
      logic       div_mul;
      logic       div_step;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       wr_sd;
      logic       err_rd;
      logic       wr_err;
      logic       valid_set;
      logic       valid_fail;
      logic       w_rd;
      logic       out_load;
      logic       out_last;
      logic [2:0] mode;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic pipe_busy;
   } status_type;

   // window length for a mode, zero for non-window modes
   function automatic logic [3:0] win_size(input logic [2:0] mode);
      case (mode)
         MODE_SD3:  win_size = 4'd3;
         MODE_SD5:  win_size = 4'd5;
         MODE_SD7:  win_size = 4'd7;
         MODE_SD11: win_size = 4'd11;
         default:   win_size = 4'd0;
      endcase
   endfunction

   // divisor W*(W-1) for a mode
   function automatic logic [6:0] win_div(input logic [2:0] mode);
      case (mode)
         MODE_SD3:  win_div = 7'd6;
         MODE_SD5:  win_div = 7'd20;
         MODE_SD7:  win_div = 7'd42;
         MODE_SD11: win_div = 7'd110;
         default:   win_div = 7'd1;
      endcase
   endfunction

   // ceil(2^30 / (W*(W-1))), exact quotient for any 23-bit digit dividend
   function automatic logic [27:0] win_recip(input logic [2:0] mode);
      case (mode)
         MODE_SD3:  win_recip = 28'd178956971;
         MODE_SD5:  win_recip = 28'd53687092;
         MODE_SD7:  win_recip = 28'd25565282;
         MODE_SD11: win_recip = 28'd9761290;
         default:   win_recip = 28'd0;
      endcase
   endfunction

endpackage

[rtl/running_window_stddev_weights_core.sv]
// Running window standard deviation weights: top level. Points stream in at
// one per cycle and are stored; the beat marked last starts the weight pass.
// Run-error mode reads each point's error value and stores it as its weight.
// Running SD over a window of W runs, per point, a pair sum pipeline with one
// read pair a cycle and a drain, a divide by W*(W-1) that takes five 16-bit
// digits by reciprocal multiplication, and a 31-step square root. Each weight
// is then read out, loaded into the output register and held through any
// stall on the result side. No new point is taken until the last weight of the
// curve has been delivered. Points beyond MAX_POINTS are dropped.
module running_window_stddev_weights_core import rwsd_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // sample_value [31:0], error_value [63:32]
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // weight [31:0]
   output logic        rsp_tuser,   // weights_ok
   output logic        rsp_tlast,   // last_weight
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   localparam int IW = $clog2(MAX_POINTS);

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] wr_addr, addr_a, addr_b, pt_addr;

   // sequencer
   rwsd_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd),
      .wr_addr     (wr_addr),
      .addr_a      (addr_a),
      .addr_b      (addr_b),
      .pt_addr     (pt_addr)
   );

   // arithmetic and storage
   rwsd_dpath #(.MAX_POINTS(MAX_POINTS)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .wr_addr    (wr_addr),
      .addr_a     (addr_a),
      .addr_b     (addr_b),
      .pt_addr    (pt_addr),
      .in_sample  (req_tdata[31:0]),
      .in_error   (req_tdata[63:32]),
      .out_weight (rsp_tdata),
      .out_ok     (rsp_tuser),
      .out_last   (rsp_tlast)
   );

endmodule

[rtl/rwsd_ctrl.sv]
// controller state machine: load, per-point window or error-copy sequencing and result emission
module rwsd_ctrl import rwsd_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int IW = $clog2(MAX_POINTS),
   parameter int CW = $clog2(MAX_POINTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_wr_en,
   input  logic [2:0]    csr_wr_data,
   input  status_type    status,
   output cmd_type       cmd,
   output logic [IW-1:0] wr_addr,
   output logic [IW-1:0] addr_a,
   output logic [IW-1:0] addr_b,
   output logic [IW-1:0] pt_addr
);

   state_type     state_ff, state_in;
   logic [2:0]    mode_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] n_ff, n_in;
   logic [IW-1:0] pi_ff, pi_in;
   logic [CW-1:0] start_ff, start_in;
   logic [3:0]    ii_ff, ii_in, jj_ff, jj_in;
   logic [6:0]    step_ff, step_in;
   logic [3:0]    win;
   logic [3:0]    half;
   logic [CW-1:0] st_raw;
   logic          pt_last;
   logic          accept;

   assign win     = win_size(mode_ff);
   assign half    = win >> 1;
   assign accept  = req_tvalid && req_tready;
   assign pt_last = (CW'(pi_ff) == n_ff - CW'(1));

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EWAIT);

   assign wr_addr = cnt_ff[IW-1:0];
   assign addr_a  = IW'(start_ff + CW'(ii_ff));
   assign addr_b  = IW'(start_ff + CW'(jj_ff));
   assign pt_addr = pi_ff;

   // window start, shifted inward at the curve edges
   always_comb begin
      if ((CW + 4)'(pi_ff) >= (CW + 4)'(half)) begin
         st_raw = CW'((CW + 4)'(pi_ff) - (CW + 4)'(half));
      end else begin
         st_raw = '0;
      end
      if ((CW + 4)'(st_raw) + (CW + 4)'(win) > (CW + 4)'(n_ff)) begin
         start_in = CW'((CW + 4)'(n_ff) - (CW + 4)'(win));
      end else begin
         start_in = st_raw;
      end
      if (state_ff != ST_WIN) begin
         start_in = start_ff;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      pi_in    = pi_ff;
      ii_in    = ii_ff;
      jj_in    = jj_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.mode = mode_ff;
      cmd.out_last = pt_last;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cnt_ff < CW'(MAX_POINTS)) begin
                  cmd.load_wr = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end
               if (req_tlast) begin
                  n_in = (cnt_ff < CW'(MAX_POINTS)) ? cnt_ff + CW'(1) : cnt_ff;
                  cnt_in = '0;
                  cmd.valid_set = 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            pi_in = '0;
            if (mode_ff == MODE_ERROR) begin
               state_in = ST_CRD;
            end else if (win != 4'd0 && (CW + 4)'(n_ff) >= (CW + 4)'(win)) begin
               state_in = ST_WIN;
            end else begin
               cmd.valid_fail = 1'b1;
               state_in = ST_ERD;
            end
         end
         ST_WIN: begin
            cmd.acc_clear = 1'b1;
            ii_in = 4'd0;
            jj_in = 4'd1;
            state_in = ST_PAIR;
         end
         ST_PAIR: begin
            cmd.pair_issue = 1'b1;
            if (jj_ff == win - 4'd1) begin
               if (ii_ff == win - 4'd2) begin
                  state_in = ST_DRAIN;
               end else begin
                  ii_in = ii_ff + 4'd1;
                  jj_in = ii_ff + 4'd2;
               end
            end else begin
               jj_in = jj_ff + 4'd1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               step_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // multiply on even cycles, take the digit on odd cycles
            cmd.div_mul  = ~step_ff[0];
            cmd.div_step = step_ff[0];
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(DIV_STEPS - 1)) begin
               state_in = ST_SQI;
            end
         end
         ST_SQI: begin
            cmd.sqrt_init = 1'b1;
            step_in = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(SQRT_STEPS - 1)) begin
               state_in = ST_WRSD;
            end
         end
         ST_WRSD: begin
            cmd.wr_sd = 1'b1;
            if (pt_last) begin
               pi_in = '0;
               state_in = ST_ERD;
            end else begin
               pi_in = pi_ff + IW'(1);
               state_in = ST_WIN;
            end
         end
         ST_CRD: begin
            cmd.err_rd = 1'b1;
            state_in = ST_CWR;
         end
         ST_CWR: begin
            cmd.wr_err = 1'b1;
            if (pt_last) begin
               pi_in = '0;
               state_in = ST_ERD;
            end else begin
               pi_in = pi_ff + IW'(1);
               state_in = ST_CRD;
            end
         end
         ST_ERD: begin
            cmd.w_rd = 1'b1;
            state_in = ST_ELD;
         end
         ST_ELD: begin
            cmd.out_load = 1'b1;
            state_in = ST_EWAIT;
         end
         ST_EWAIT: begin
            if (rsp_tready) begin
               if (pt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pi_in = pi_ff + IW'(1);
                  state_in = ST_ERD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_EQUAL;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   // counters and window position
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      pi_ff    <= pi_in;
      start_ff <= start_in;
      ii_ff    <= ii_in;
      jj_ff    <= jj_in;
      step_ff  <= step_in;
   end

endmodule

[rtl/rwsd_dpath.sv]
// datapath: point stores, pair sum pipeline, constant divider, square root and output register
module rwsd_dpath import rwsd_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int IW = $clog2(MAX_POINTS)
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output status_type    status,
   input  logic [IW-1:0] wr_addr,
   input  logic [IW-1:0] addr_a,
   input  logic [IW-1:0] addr_b,
   input  logic [IW-1:0] pt_addr,
   input  logic [31:0]   in_sample,
   input  logic [31:0]   in_error,
   output logic [31:0]   out_weight,
   output logic          out_ok,
   output logic          out_last
);

   logic [31:0] sample_mem [MAX_POINTS];
   logic [31:0] error_mem  [MAX_POINTS];
   logic [31:0] weight_mem [MAX_POINTS];

   logic [31:0]      rd_a_ff, rd_b_ff, err_rd_ff, w_rd_ff;
   logic [2:0]       v_ff;
   logic [31:0]      diff_ff;
   logic [63:0]      prod_ff;
   logic [32:0]      diff_s;
   logic [31:0]      diff_in;
   logic [ACC_W-1:0] acc_ff;
   logic [6:0]       rem_ff;
   logic [6:0]       dvs;
   logic [27:0]      recip;
   logic [22:0]      div_cur;
   logic [50:0]      qprod_ff;
   logic [15:0]      div_q;
   logic [22:0]      div_rem;
   logic [61:0]      x_ff, res_ff, trial;
   logic [60:0]      bit_ff;
   logic             sat_ff;
   logic [31:0]      sd_val;
   logic             valid_ff;

   assign status.pipe_busy = |v_ff;
   assign dvs     = win_div(cmd.mode);
   assign recip   = win_recip(cmd.mode);
   assign div_cur = {rem_ff, acc_ff[ACC_W-1 -: 16]};
   assign div_q   = qprod_ff[45:30];
   assign div_rem = div_cur - 23'(div_q) * 23'(dvs);
   assign trial   = res_ff + {1'b0, bit_ff};
   assign sd_val  = sat_ff ? SAT_W : res_ff[31:0];

   // absolute difference of two signed samples
   always_comb begin
      diff_s  = {rd_a_ff[31], rd_a_ff} - {rd_b_ff[31], rd_b_ff};
      diff_in = diff_s[32] ? 32'(-diff_s) : diff_s[31:0];
   end

   // point stores
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         sample_mem[wr_addr] <= in_sample;
         error_mem[wr_addr]  <= in_error;
      end
      rd_a_ff   <= sample_mem[addr_a];
      rd_b_ff   <= sample_mem[addr_b];
      err_rd_ff <= error_mem[pt_addr];
   end

   // weight store
   always_ff @(posedge clock) begin
      if (cmd.wr_sd) begin
         weight_mem[pt_addr] <= sd_val;
      end else if (cmd.wr_err) begin
         weight_mem[pt_addr] <= err_rd_ff;
      end
      w_rd_ff <= weight_mem[pt_addr];
   end

   // pair pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], cmd.pair_issue};
      end
   end

   // squared difference stages
   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      prod_ff <= 64'(diff_ff) * 64'(diff_ff);
   end

   // reciprocal product of the remainder and the current 16-bit dividend digit
   always_ff @(posedge clock) begin
      if (cmd.div_mul) begin
         qprod_ff <= {28'd0, div_cur} * {23'd0, recip};
      end
   end

   // pair sum accumulator, reused as dividend and quotient
   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         acc_ff <= '0;
         rem_ff <= '0;
      end else if (v_ff[2]) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end else if (cmd.div_step) begin
         rem_ff <= div_rem[6:0];
         acc_ff <= {acc_ff[ACC_W-17:0], div_q};
      end
   end

   // bitwise integer square root of the variance
   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sat_ff <= |acc_ff[ACC_W-1:62];
         x_ff   <= acc_ff[61:0];
         res_ff <= '0;
         bit_ff <= 61'(1) << 60;
      end else if (cmd.sqrt_step) begin
         if (x_ff >= trial) begin
            x_ff   <= x_ff - trial;
            res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // all-weights-nonzero flag, also cleared when no window fits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b1;
      end else if (cmd.valid_set) begin
         valid_ff <= 1'b1;
      end else if (cmd.valid_fail) begin
         valid_ff <= 1'b0;
      end else if (cmd.wr_sd && sd_val == 32'd0) begin
         valid_ff <= 1'b0;
      end else if (cmd.wr_err && err_rd_ff == 32'd0) begin
         valid_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_weight <= valid_ff ? w_rd_ff : ONE_Q16;
         out_ok     <= valid_ff || (cmd.mode == MODE_EQUAL);
         out_last   <= cmd.out_last;
      end
   end

endmodule

[rtl/rwsd_checker.sv]
// port-level checker for the running window stddev weights core, with its bind
module rwsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // input is never taken while a weight is being offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while result valid");

   // block comes out of reset ready for points and not offering results
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("not idle after reset");

   // a stalled result stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result valid dropped while stalled");

   // a stalled result beat holds its payload
   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         ($stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result payload changed while stalled");

endmodule

bind running_window_stddev_weights_core rwsd_checker u_rwsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
